/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the subscription table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Delayed implication, disabled while reset is asserted.
`define ASSERT_AFTER2(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed: two-cycle implication");

`endif

/* design/pst_pkg.sv */
// ----------------------------------------------------------------------------
// pst_pkg
// Types and constants of the property subscription table.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int MAX_SUBS    = 4;
    localparam int CNT_W       = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0] CNT_ONE = 16'd1;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SUBS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALL_MASK = 1'd1;

    // Per-subscriber entry codes; the fourth code is corrupt
    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_SUB  = 2'd1;
    localparam logic [1:0] CODE_ONCE = 2'd2;

    typedef enum logic [1:0] {
        CMD_SET       = 2'd0,
        CMD_ONCE      = 2'd1,
        CMD_QUERY_ONE = 2'd2,
        CMD_QUERY_ALL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        cmd_t       command;
        logic [1:0] sub_id;
        logic       flag;
    } req_t;

    typedef struct packed {
        logic                status;
        logic                hit;
        logic [MAX_SUBS-1:0] mask;
    } res_t;

endpackage

/* design/pst_update.sv */
// ----------------------------------------------------------------------------
// pst_update
// Modify step: new entry, new counters and the answer for one request.
// ----------------------------------------------------------------------------
module pst_update #(
    parameter int SUBSCRIBERS = 4
) (
    input  pst_pkg::req_t                                    req,
    input  logic [2*SUBSCRIBERS-1:0]                         entry,
    input  logic [SUBSCRIBERS-1:0][pst_pkg::CNT_W-1:0]       cnt,
    input  logic [pst_pkg::CNT_W-1:0]                        max_subs,
    input  logic [SUBSCRIBERS-1:0]                           all_mask,
    output logic [2*SUBSCRIBERS-1:0]                         entry_upd,
    output logic [SUBSCRIBERS-1:0][pst_pkg::CNT_W-1:0]       cnt_upd,
    output pst_pkg::res_t                                    res
);

    logic sub_ok;

    assign sub_ok = ({1'b0, req.sub_id} < 3'(SUBSCRIBERS));

    always_comb
    begin
        logic [1:0] code;
        logic [1:0] new_code;
        logic       sel;
        logic       do_sub;
        logic       do_drop;

        entry_upd = entry;
        cnt_upd   = cnt;
        res       = '0;
        for (int i = 0; i < SUBSCRIBERS; i++)
        begin
            code     = entry[2*i +: 2];
            sel      = sub_ok && (req.sub_id == 2'(i));
            new_code = pst_pkg::CODE_SUB;
            do_sub   = 1'b0;
            do_drop  = 1'b0;

            unique case (req.command)
                pst_pkg::CMD_SET:
                begin
                    if (sel)
                    begin
                        do_sub  = req.flag;
                        do_drop = !req.flag;
                    end
                end
                pst_pkg::CMD_ONCE:
                begin
                    do_sub   = sel;
                    new_code = pst_pkg::CODE_ONCE;
                end
                pst_pkg::CMD_QUERY_ONE:
                begin
                    if (sel)
                    begin
                        if (all_mask[i])
                        begin
                            res.hit = 1'b1;
                        end
                        else
                        begin
                            // consume single-use marks, scrub corrupt codes
                            res.hit = (code == pst_pkg::CODE_SUB) ||
                                      (code == pst_pkg::CODE_ONCE);
                            do_drop = (code != pst_pkg::CODE_SUB) &&
                                      (code != pst_pkg::CODE_NONE);
                        end
                    end
                end
                pst_pkg::CMD_QUERY_ALL:
                begin
                    res.mask[i] = (code == pst_pkg::CODE_SUB) ||
                                  (code == pst_pkg::CODE_ONCE);
                    do_drop     = (code != pst_pkg::CODE_SUB) &&
                                  (code != pst_pkg::CODE_NONE);
                end
            endcase

            if (do_sub)
            begin
                if (cnt[i] < max_subs)
                begin
                    cnt_upd[i]         = cnt[i] + pst_pkg::CNT_ONE;
                    entry_upd[2*i +: 2] = new_code;
                end
                else
                begin
                    res.status = 1'b1;
                end
            end
            if (do_drop)
            begin
                entry_upd[2*i +: 2] = pst_pkg::CODE_NONE;
                if (cnt[i] != '0)
                begin
                    cnt_upd[i] = cnt[i] - pst_pkg::CNT_ONE;
                end
            end
        end
    end

endmodule

/* design/property_subscription_table_top.sv */
// ----------------------------------------------------------------------------
// property_subscription_table_top
// Subscription table keyed by property type and number, with per-subscriber
// codes, limited subscription counters and query commands.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake             payload
//  -------   ---------  --------------------  ---------------------------------
//  request   in         in_valid / in_stall   command, prop_type, property_id,
//                                             subscriber_id, subscribe_flag
//  result    out        out_valid / out_stall status, is_subscribed,
//                                             subscriber_mask
//  config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An item is accepted in IDLE, where the accept edge issues the table read;
//  in EXEC the modify step runs and the entry is written back into the table
//  memory, so no new item is taken until that write-back is done.
//  The result is loaded into the output register at the end of EXEC and can
//  be taken at the following edge at the earliest.
//  After reset a clearing pass writes zero to all 2^(TYPE_BITS+PROPERTY_BITS)
//  entries, one per cycle (65536 entries at the defaults); no item is taken
//  meanwhile, configuration writes are.
//  A stalled result holds in the output register; one more item may be taken
//  while it waits only if it is being taken at the same edge.
//
module property_subscription_table_top #(
    parameter int TYPE_BITS     = 4,
    parameter int PROPERTY_BITS = 12,
    parameter int SUBSCRIBERS   = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         command,
    input  logic [TYPE_BITS-1:0]               prop_type,
    input  logic [PROPERTY_BITS-1:0]           property_id,
    input  logic [1:0]                         subscriber_id,
    input  logic                               subscribe_flag,
    // result channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic                               is_subscribed,
    output logic [pst_pkg::MAX_SUBS-1:0]       subscriber_mask,
    // configuration channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pst_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pst_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int KEY_BITS    = TYPE_BITS + PROPERTY_BITS;
    localparam int TABLE_DEPTH = 2 ** KEY_BITS;
    localparam int ENTRY_W     = 2 * SUBSCRIBERS;

    // Table memory: one write and one registered read per cycle
    logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];

    pst_pkg::state_t state_reg, state_next;

    logic [KEY_BITS-1:0]                          clear_addr_reg;
    logic [KEY_BITS-1:0]                          key_in;
    logic [KEY_BITS-1:0]                          key_reg;
    pst_pkg::req_t                                req_in;
    pst_pkg::req_t                                req_reg;
    logic [ENTRY_W-1:0]                           rd_data_reg;

    logic [SUBSCRIBERS-1:0][pst_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUBSCRIBERS-1:0][pst_pkg::CNT_W-1:0]   cnt_upd;
    logic [pst_pkg::CNT_W-1:0]                    max_subs_reg;
    logic [SUBSCRIBERS-1:0]                       all_mask_reg;

    logic [ENTRY_W-1:0]                           entry_upd;
    pst_pkg::res_t                                res;

    logic                                         out_valid_reg;
    logic                                         status_reg;
    logic                                         hit_reg;
    logic [pst_pkg::MAX_SUBS-1:0]                 mask_reg;

    logic                                         accept;
    logic                                         exec;
    logic                                         mem_we;
    logic [KEY_BITS-1:0]                          mem_waddr;
    logic [ENTRY_W-1:0]                           mem_wdata;

    assign key_in         = {prop_type, property_id};
    assign req_in.command = pst_pkg::cmd_t'(command);
    assign req_in.sub_id  = subscriber_id;
    assign req_in.flag    = subscribe_flag;

    // The user must write configuration only while the block is idle; the block itself does not enforce it
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Sequencer: clearing pass, then accept / modify-and-write-back
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        accept     = 1'b0;
        exec       = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = key_reg;
        mem_wdata  = entry_upd;
        unique case (state_reg)
            pst_pkg::ST_CLEAR:
            begin
                // zero one entry per cycle until the last address
                mem_we    = 1'b1;
                mem_waddr = clear_addr_reg;
                mem_wdata = '0;
                if (&clear_addr_reg)
                begin
                    state_next = pst_pkg::ST_IDLE;
                end
            end
            pst_pkg::ST_IDLE:
            begin
                // hold off while a result waits and is not being taken
                in_stall = out_valid_reg && out_stall;
                accept   = in_valid && !in_stall;
                if (accept)
                begin
                    state_next = pst_pkg::ST_EXEC;
                end
            end
            pst_pkg::ST_EXEC:
            begin
                exec       = 1'b1;
                mem_we     = 1'b1;
                state_next = pst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pst_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
        end
        else if (state_reg == pst_pkg::ST_CLEAR)
        begin
            clear_addr_reg <= clear_addr_reg + KEY_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // Table memory and request capture
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= entry_mem[key_in];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= key_in;
            req_reg <= req_in;
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_subs_reg <= '0;
            all_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pst_pkg::CFG_MAX_SUBS: max_subs_reg <= cfg_data;
                pst_pkg::CFG_ALL_MASK: all_mask_reg <= cfg_data[SUBSCRIBERS-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Modify step and counters
    // ------------------------------------------------------------------
    pst_update #(
        .SUBSCRIBERS (SUBSCRIBERS)
    ) u_update (
        .req       (req_reg),
        .entry     (rd_data_reg),
        .cnt       (cnt_reg),
        .max_subs  (max_subs_reg),
        .all_mask  (all_mask_reg),
        .entry_upd (entry_upd),
        .cnt_upd   (cnt_upd),
        .res       (res)
    );

    assign cnt_next = exec ? cnt_upd : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            status_reg <= res.status;
            hit_reg    <= res.hit;
            mask_reg   <= res.mask;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign is_subscribed   = hit_reg;
    assign subscriber_mask = mask_reg;

endmodule

/* design/pst_checker.sv */
// ----------------------------------------------------------------------------
// pst_checker
// Port-level checks of the subscription table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pst_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         status,
    input logic                         is_subscribed,
    input logic [pst_pkg::MAX_SUBS-1:0] subscriber_mask
);

    // A stalled result stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // One item in flight: the edge after an accept takes nothing
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

    // Every accepted item shows a result once its EXEC step is done
    `ASSERT_AFTER2(a_result_lat, clk, rst_n, in_valid && !in_stall, out_valid)

    // A limit refusal comes only from commands with no query answer
    `ASSERT_IMPLIES(a_status_excl, clk, rst_n, out_valid && status,
        !is_subscribed && (subscriber_mask == '0))

endmodule

bind property_subscription_table_top pst_checker u_pst_checker (.*);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the property subscription table: a directed table
// of requests and register settings, then random traffic over six register
// settings, each result checked field by field against a typed answer or an in-bench model.
// ----------------------------------------------------------------------------
module testbench;

    import pst_pkg::*;

    // Clearing pass over 65536 entries plus ~560 items under heavy receiver
    // stalls stays far below this.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 88;
    localparam int KEY_POOL_SIZE = 8;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    // One row of the directed table: a request, or a register setting.
    // The answer is {status, is_subscribed, subscriber_mask} and is only used
    // where typed is set; other rows take the model's answer.
    typedef struct packed {
        row_kind_t   kind;
        cmd_t        cmd;
        logic [3:0]  ptype;
        logic [11:0] prop;
        logic [1:0]  sub;
        logic        flag;
        logic        typed;
        res_t        answer;
        logic [15:0] cfg_max;
        logic [3:0]  cfg_mask;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n          = 1'b0;
    logic                    in_valid       = 1'b0;
    logic                    in_stall;
    logic [1:0]              command        = 2'd0;
    logic [3:0]              prop_type      = 4'd0;
    logic [11:0]             property_id    = 12'd0;
    logic [1:0]              subscriber_id  = 2'd0;
    logic                    subscribe_flag = 1'b0;
    logic                    out_valid;
    logic                    out_stall      = 1'b0;
    logic                    status;
    logic                    is_subscribed;
    logic [MAX_SUBS-1:0]     subscriber_mask;
    logic                    cfg_valid      = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index      = CFG_MAX_SUBS;
    logic [CFG_DATA_W-1:0]   cfg_data       = '0;

    // Model of the block: entry codes, subscription counters, registers
    logic [7:0]  entry_model [0:65535];
    logic [15:0] sub_count_model [0:MAX_SUBS-1];
    logic [15:0] limit_model;
    logic [3:0]  all_mask_model;

    res_t        pending_results [$];
    res_t        head_result;
    stim_row_t   directed_rows [$];
    logic [15:0] key_pool [KEY_POOL_SIZE];

    int sender_gap_pct     = 12;
    int receiver_stall_pct = 75;
    int cycle_count        = 0;
    int error_count        = 0;
    int items_sent         = 0;
    int results_checked    = 0;
    int blocked_count      = 0;
    int positive_count     = 0;

    property_subscription_table_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .prop_type      (prop_type),
        .property_id    (property_id),
        .subscriber_id  (subscriber_id),
        .subscribe_flag (subscribe_flag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .is_subscribed  (is_subscribed),
        .subscriber_mask(subscriber_mask),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Write one subscriber code; a subscribe at the limit leaves everything
    // alone and reports status 1, an unsubscribe always clears the code.
    function automatic logic store_code(logic [15:0] key, int sub, logic [1:0] code);
        if (code != CODE_NONE)
        begin
            if (sub_count_model[sub] < limit_model)
            begin
                sub_count_model[sub] = sub_count_model[sub] + CNT_ONE;
                entry_model[key][2*sub +: 2] = code;
                return 1'b0;
            end
            return 1'b1;
        end
        if (sub_count_model[sub] != '0)
            sub_count_model[sub] = sub_count_model[sub] - CNT_ONE;
        entry_model[key][2*sub +: 2] = CODE_NONE;
        return 1'b0;
    endfunction

    // Answer one request and advance the model state.
    function automatic res_t predict_answer(cmd_t cmd, logic [3:0] ptype,
                                            logic [11:0] prop, logic [1:0] sub,
                                            logic flag);
        res_t        r;
        logic [15:0] key;
        logic [1:0]  code;
        r   = '0;
        key = {ptype, prop};
        case (cmd)
            CMD_SET:
                r.status = store_code(key, sub, flag ? CODE_SUB : CODE_NONE);
            CMD_ONCE:
                r.status = store_code(key, sub, CODE_ONCE);
            CMD_QUERY_ONE:
                if (all_mask_model[sub])
                    r.hit = 1'b1;
                else
                begin
                    code = entry_model[key][2*sub +: 2];
                    if (code == CODE_SUB)
                        r.hit = 1'b1;
                    else if (code == CODE_ONCE)
                    begin
                        void'(store_code(key, sub, CODE_NONE));
                        r.hit = 1'b1;
                    end
                    else if (code != CODE_NONE)
                        void'(store_code(key, sub, CODE_NONE));
                end
            default:
                for (int i = 0; i < MAX_SUBS; i++)
                begin
                    code = entry_model[key][2*i +: 2];
                    if (code == CODE_SUB)
                        r.mask[i] = 1'b1;
                    else if (code == CODE_ONCE)
                    begin
                        void'(store_code(key, i, CODE_NONE));
                        r.mask[i] = 1'b1;
                    end
                    else if (code != CODE_NONE)
                        void'(store_code(key, i, CODE_NONE));
                end
        endcase
        return r;
    endfunction

    function automatic stim_row_t item_row(cmd_t cmd, logic [3:0] ptype,
                                           logic [11:0] prop, logic [1:0] sub,
                                           logic flag, logic typed, res_t answer);
        stim_row_t r;
        r        = '0;
        r.kind   = ROW_ITEM;
        r.cmd    = cmd;
        r.ptype  = ptype;
        r.prop   = prop;
        r.sub    = sub;
        r.flag   = flag;
        r.typed  = typed;
        r.answer = answer;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(logic [15:0] max_subs, logic [3:0] all_mask);
        stim_row_t r;
        r          = '0;
        r.kind     = ROW_CFG;
        r.cfg_max  = max_subs;
        r.cfg_mask = all_mask;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Present one item, hold it until taken, then queue its answer: the typed
    // one where given, the model's otherwise. The model runs either way so
    // that its table stays in step.
    task automatic send_request(input cmd_t cmd, input logic [3:0] ptype,
                                input logic [11:0] prop, input logic [1:0] sub,
                                input logic flag, input logic typed,
                                input res_t answer);
        res_t predicted;
        in_valid       <= 1'b1;
        command        <= cmd;
        prop_type      <= ptype;
        property_id    <= prop;
        subscriber_id  <= sub;
        subscribe_flag <= flag;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_answer(cmd, ptype, prop, sub, flag);
        pending_results.push_back(typed ? answer : predicted);
        items_sent++;
        blocked_count  += predicted.status;
        positive_count += (predicted.hit || predicted.mask != '0);
    endtask

    // Drop valid for a few cycles now and then
    task automatic pace_sender();
        if ($urandom_range(99) < sender_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back, valid held high across the pair
    task automatic program_registers(input logic [15:0] max_subs,
                                     input logic [3:0] all_mask);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_SUBS;
        cfg_data  <= max_subs;
        do
            @(posedge clk);
        while (!cfg_ready);
        limit_model = max_subs;
        cfg_index <= CFG_ALL_MASK;
        cfg_data  <= CFG_DATA_W'(all_mask);
        do
            @(posedge clk);
        while (!cfg_ready);
        all_mask_model = all_mask;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: take results, check against the oldest expectation, and
    // pick the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: status=%0d is_subscribed=%0d mask=%h",
                       status, is_subscribed, subscriber_mask);
                error_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (status !== head_result.status)
                begin
                    $error("status: expected %0d, got %0d", head_result.status, status);
                    error_count++;
                end
                if (is_subscribed !== head_result.hit)
                begin
                    $error("is_subscribed: expected %0d, got %0d",
                           head_result.hit, is_subscribed);
                    error_count++;
                end
                if (subscriber_mask !== head_result.mask)
                begin
                    $error("subscriber_mask: expected %h, got %h",
                           head_result.mask, subscriber_mask);
                    error_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t   row;
        logic [15:0] key;
        logic [15:0] seg_max  [SEGMENTS];
        logic [3:0]  seg_mask [SEGMENTS];

        // Register settings of the random part; both limits' extremes appear
        seg_max  = '{16'd65535, 16'd2, 16'd0, 16'd5, 16'd65535, 16'd1};
        seg_mask = '{4'h0, 4'h5, 4'hF, 4'h0, 4'hA, 4'h3};

        // Model reset: table cleared, counters and registers zero
        foreach (entry_model[k])
            entry_model[k] = '0;
        foreach (sub_count_model[k])
            sub_count_model[k] = '0;
        limit_model    = '0;
        all_mask_model = '0;

        // Concentrate random traffic on a few keys so entries get revisited
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int k = 2; k < KEY_POOL_SIZE; k++)
            key_pool[k] = 16'($urandom);

        // Directed table. Answers read {status, is_subscribed, mask}.
        directed_rows = '{
            cfg_row(16'd3, 4'h0),
            // Fresh table: nothing subscribed anywhere
            item_row(CMD_QUERY_ALL, 4'd0, 12'd0, 2'd3, 1'b1, 1'b1, 6'b0_0_0000),
            item_row(CMD_QUERY_ONE, 4'd15, 12'd4095, 2'd0, 1'b1, 1'b1, 6'b0_0_0000),
            // Subscribe, then subscribe again: both count
            item_row(CMD_SET, 4'd0, 12'd0, 2'd0, 1'b1, 1'b1, 6'b0_0_0000),
            item_row(CMD_QUERY_ONE, 4'd0, 12'd0, 2'd0, 1'b0, 1'b1, 6'b0_1_0000),
            item_row(CMD_SET, 4'd0, 12'd0, 2'd0, 1'b1, 1'b1, 6'b0_0_0000),
            item_row(CMD_ONCE, 4'd15, 12'd4095, 2'd0, 1'b0, 1'b1, 6'b0_0_0000),
            // Counter at the limit: blocked, entry untouched
            item_row(CMD_SET, 4'd1, 12'd1, 2'd0, 1'b1, 1'b1, 6'b1_0_0000),
            item_row(CMD_ONCE, 4'd1, 12'd1, 2'd0, 1'b1, 1'b1, 6'b1_0_0000),
            item_row(CMD_QUERY_ONE, 4'd1, 12'd1, 2'd0, 1'b0, 1'b1, 6'b0_0_0000),
            // Single use is consumed by the first query
            item_row(CMD_QUERY_ALL, 4'd15, 12'd4095, 2'd1, 1'b0, 1'b1, 6'b0_0_0001),
            item_row(CMD_QUERY_ALL, 4'd15, 12'd4095, 2'd2, 1'b1, 1'b1, 6'b0_0_0000),
            // Unsubscribe down to zero and once more past it
            item_row(CMD_SET, 4'd0, 12'd0, 2'd0, 1'b0, 1'b1, 6'b0_0_0000),
            item_row(CMD_SET, 4'd0, 12'd0, 2'd0, 1'b0, 1'b1, 6'b0_0_0000),
            item_row(CMD_SET, 4'd0, 12'd0, 2'd0, 1'b0, 1'b1, 6'b0_0_0000),
            // Mixed codes of several subscribers on one entry
            item_row(CMD_SET, 4'd15, 12'd4095, 2'd3, 1'b1, 1'b0, '0),
            item_row(CMD_ONCE, 4'd15, 12'd4095, 2'd1, 1'b0, 1'b0, '0),
            item_row(CMD_SET, 4'd15, 12'd4095, 2'd2, 1'b1, 1'b0, '0),
            item_row(CMD_QUERY_ALL, 4'd15, 12'd4095, 2'd0, 1'b0, 1'b0, '0),
            item_row(CMD_QUERY_ONE, 4'd15, 12'd4095, 2'd1, 1'b1, 1'b0, '0),
            item_row(CMD_ONCE, 4'd5, 12'h555, 2'd2, 1'b0, 1'b0, '0),
            item_row(CMD_QUERY_ONE, 4'd5, 12'h555, 2'd2, 1'b0, 1'b0, '0),
            // Limit zero, subscribe-all on subscribers 1 and 3
            cfg_row(16'd0, 4'b1010),
            item_row(CMD_QUERY_ONE, 4'd1, 12'd1, 2'd1, 1'b0, 1'b1, 6'b0_1_0000),
            item_row(CMD_QUERY_ONE, 4'd1, 12'd1, 2'd3, 1'b0, 1'b1, 6'b0_1_0000),
            item_row(CMD_SET, 4'd10, 12'hAAA, 2'd3, 1'b1, 1'b1, 6'b1_0_0000),
            // Query all ignores subscribe-all
            item_row(CMD_QUERY_ALL, 4'd15, 12'd4095, 2'd1, 1'b0, 1'b0, '0),
            item_row(CMD_SET, 4'd15, 12'd4095, 2'd3, 1'b0, 1'b0, '0),
            item_row(CMD_ONCE, 4'd10, 12'hAAA, 2'd1, 1'b0, 1'b1, 6'b1_0_0000)
        };

        // Hold reset, then release it on a clock edge
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: sender idles lightly, receiver stalls heavily
        sender_gap_pct     = 12;
        receiver_stall_pct = 75;
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            if (row.kind == ROW_CFG)
            begin
                drain_results();
                program_registers(row.cfg_max, row.cfg_mask);
            end
            else
            begin
                send_request(row.cmd, row.ptype, row.prop, row.sub, row.flag,
                             row.typed, row.answer);
                pace_sender();
            end
        end

        // Random part: two segments per idling mode, new registers each time
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    sender_gap_pct     = 12;
                    receiver_stall_pct = 75;
                end
                1:
                begin
                    sender_gap_pct     = 75;
                    receiver_stall_pct = 12;
                end
                default:
                begin
                    sender_gap_pct     = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            drain_results();
            program_registers(seg_max[seg], seg_mask[seg]);
            for (int n = 0; n < SEGMENT_ITEMS; n++)
            begin
                key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                                : 16'($urandom);
                send_request(cmd_t'($urandom_range(3)), key[15:12], key[11:0],
                             2'($urandom_range(3)), 1'($urandom_range(1)), 1'b0, '0);
                // Once mid-segment, hold off until the pipeline is empty
                if (seg == 3 && n == SEGMENT_ITEMS / 2)
                    drain_results();
                else
                    pace_sender();
            end
        end

        // Wait out the last results, then keep clocking to catch strays
        drain_results();
        repeat (8) @(posedge clk);

        $display("ran %0d requests (%0d directed) across %0d register settings",
                 items_sent, items_sent - SEGMENTS * SEGMENT_ITEMS, SEGMENTS + 2);
        $display("checked %0d results: %0d subscribes blocked at the limit, %0d positive answers",
                 results_checked, blocked_count, positive_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
